/* rtl/deq_pkg.sv */
// Shared constants, types and helpers for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int FIELD_W = 32;
    localparam int POS_W   = 4;
    localparam int CMD_W   = 3;
    localparam int CNT_OUT_W = 5;
    localparam int STAT_W  = 2;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (DATA_W < FIELD_W) ? DATA_W : FIELD_W;
    localparam int OFF_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } t_state;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [OFF_W-1:0]   t_off;
    typedef logic [STORE_W-1:0] t_data;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        logic  re_a;
        t_addr raddr_a;
        logic  re_b;
        t_addr raddr_b;
    } t_mem_req;

    typedef struct packed {
        t_data rdata_a;
        t_data rdata_b;
    } t_mem_rsp;

    // Ring slot at an offset from the head; offset below DEPTH for live slots.
    function automatic t_addr slot_at(t_addr head, t_off off);
        logic [OFF_W:0] sum;
        sum = (OFF_W + 1)'(head) + (OFF_W + 1)'(off);
        if (sum >= (OFF_W + 1)'(DEPTH)) begin
            sum = sum - (OFF_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/deq_if.sv */
// Request and result channel interfaces of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
interface deq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [deq_pkg::CMD_W-1:0]   cmd;
    logic [deq_pkg::FIELD_W-1:0] push_value;
    logic [deq_pkg::POS_W-1:0]   read_position;

    modport source (output valid, output cmd, output push_value, output read_position,
                    input ready);
    modport sink   (input valid, input cmd, input push_value, input read_position,
                    output ready);
endinterface

interface deq_res_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::FIELD_W-1:0]   read_value;
    logic [deq_pkg::FIELD_W-1:0]   front_value;
    logic [deq_pkg::FIELD_W-1:0]   back_value;
    logic [deq_pkg::CNT_OUT_W-1:0] item_count;
    logic [deq_pkg::STAT_W-1:0]    status;

    modport source (output valid, output read_value, output front_value,
                    output back_value, output item_count, output status, input ready);
    modport sink   (input valid, input read_value, input front_value,
                    input back_value, input item_count, input status, output ready);
endinterface
`default_nettype wire

/* rtl/double_ended_queue_top.sv */
// Top level of the ring-buffer double-ended queue.
// The sequencer writes at acceptance in ST_IDLE, reads front and back through the
//   two read ports of the element store in ST_FETCH, and registers the result in
//   ST_LOAD once the output register is free; requests are taken only in ST_IDLE.
// The next request is accepted while a result still waits in the output register.
// Reset (synchronous, active low) clears head, count, sequencer and result valid;
//   element store contents are not cleared and are only used once written.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    deq_cmd_if.sink   i_cmd,
    deq_res_if.source o_res
);

    // memory request/response between sequencer and store
    deq_pkg::t_mem_req mem_req;
    deq_pkg::t_mem_rsp mem_rsp;

    // sequencer: decodes each request, owns head/count and the result register
    deq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .o_mem_req (mem_req),
        .i_mem_rsp (mem_rsp)
    );

    // element store: registered reads
    deq_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule
`default_nettype wire

/* rtl/deq_mem.sv */
// Element store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module deq_mem (
    input  wire logic              i_clk,
    input  wire deq_pkg::t_mem_req i_req,
    output deq_pkg::t_mem_rsp      o_rsp
);

    deq_pkg::t_data r_mem [deq_pkg::DEPTH];
    deq_pkg::t_data r_rdata_a;
    deq_pkg::t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re_a) begin
            r_rdata_a <= r_mem[i_req.raddr_a];
        end
        if (i_req.re_b) begin
            r_rdata_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rsp.rdata_a = r_rdata_a;
    assign o_rsp.rdata_b = r_rdata_b;

endmodule
`default_nettype wire

/* rtl/deq_ctrl.sv */
// Command sequencer: pointer and count update, memory access and result register.
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    deq_cmd_if.sink                i_cmd,
    deq_res_if.source              o_res,
    output deq_pkg::t_mem_req      o_mem_req,
    input  wire deq_pkg::t_mem_rsp i_mem_rsp
);

    deq_pkg::t_state  r_state, n_state;
    deq_pkg::t_addr   r_head, n_head;
    deq_pkg::t_cnt    r_count, n_count;
    deq_pkg::t_status r_status, n_status;
    logic             r_read_ok, n_read_ok;
    deq_pkg::t_data   r_read_hold;

    logic                          r_out_valid;
    logic [deq_pkg::FIELD_W-1:0]   r_out_read;
    logic [deq_pkg::FIELD_W-1:0]   r_out_front;
    logic [deq_pkg::FIELD_W-1:0]   r_out_back;
    logic [deq_pkg::CNT_OUT_W-1:0] r_out_count;
    deq_pkg::t_status              r_out_status;

    logic           cmd_acc;
    logic           out_free;
    logic           do_write;
    deq_pkg::t_addr wr_addr;
    logic           is_full;
    logic           is_empty;

    assign i_cmd.ready = (r_state == deq_pkg::ST_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign is_full     = (r_count >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign is_empty    = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                if (cmd_acc) n_state = deq_pkg::ST_FETCH;
            end
            deq_pkg::ST_FETCH: begin
                n_state = deq_pkg::ST_LOAD;
            end
            deq_pkg::ST_LOAD: begin
                if (out_free) n_state = deq_pkg::ST_IDLE;
            end
            default: n_state = deq_pkg::ST_IDLE;
        endcase
    end

    // command decode against the current head and count
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = deq_pkg::STAT_OK;
        n_read_ok = 1'b0;
        do_write  = 1'b0;
        wr_addr   = r_head;
        case (deq_pkg::t_cmd'(i_cmd.cmd))
            deq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = deq_pkg::STAT_FULL;
                end else begin
                    n_head   = (r_head == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                              : r_head - deq_pkg::ADDR_W'(1);
                    wr_addr  = n_head;
                    do_write = 1'b1;
                    n_count  = r_count + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_status = deq_pkg::STAT_FULL;
                end else begin
                    wr_addr  = deq_pkg::slot_at(r_head, deq_pkg::t_off'(r_count));
                    do_write = 1'b1;
                    n_count  = r_count + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (is_empty) begin
                    n_status = deq_pkg::STAT_EMPTY;
                end else begin
                    n_head  = deq_pkg::slot_at(r_head, deq_pkg::t_off'(1));
                    n_count = r_count - deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    n_status = deq_pkg::STAT_EMPTY;
                end else begin
                    n_count = r_count - deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::CMD_READ: begin
                if (is_empty) begin
                    n_status = deq_pkg::STAT_EMPTY;
                end else if (deq_pkg::t_off'(i_cmd.read_position)
                             >= deq_pkg::t_off'(r_count)) begin
                    n_status = deq_pkg::STAT_RANGE;
                end else begin
                    n_read_ok = 1'b1;
                end
            end
            deq_pkg::CMD_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // memory requests per state; front/back are read after the update lands
    always_comb begin
        o_mem_req         = '0;
        o_mem_req.waddr   = wr_addr;
        o_mem_req.wdata   = i_cmd.push_value[deq_pkg::STORE_W-1:0];
        o_mem_req.raddr_a = r_head;
        o_mem_req.raddr_b = r_head;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                o_mem_req.we      = cmd_acc && do_write;
                o_mem_req.re_a    = cmd_acc;
                o_mem_req.raddr_a = deq_pkg::slot_at(r_head,
                                        deq_pkg::t_off'(i_cmd.read_position));
            end
            deq_pkg::ST_FETCH: begin
                o_mem_req.re_a    = 1'b1;
                o_mem_req.raddr_a = r_head;
                o_mem_req.re_b    = 1'b1;
                o_mem_req.raddr_b = deq_pkg::slot_at(r_head,
                                        deq_pkg::t_off'(r_count - deq_pkg::CNT_W'(1)));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd_acc) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (r_state == deq_pkg::ST_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_status  <= n_status;
            r_read_ok <= n_read_ok;
        end
        if (r_state == deq_pkg::ST_FETCH) begin
            r_read_hold <= r_read_ok ? i_mem_rsp.rdata_a : '0;
        end
        if (r_state == deq_pkg::ST_LOAD && out_free) begin
            r_out_read   <= deq_pkg::FIELD_W'(r_read_hold);
            r_out_front  <= is_empty ? '0 : deq_pkg::FIELD_W'(i_mem_rsp.rdata_a);
            r_out_back   <= is_empty ? '0 : deq_pkg::FIELD_W'(i_mem_rsp.rdata_b);
            r_out_count  <= deq_pkg::CNT_OUT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.read_value  = r_out_read;
    assign o_res.front_value = r_out_front;
    assign o_res.back_value  = r_out_back;
    assign o_res.item_count  = r_out_count;
    assign o_res.status      = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("count above depth");

    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> cmd_acc)
        else $error("memory write without a request");

    a_full_push_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && is_full && (i_cmd.cmd == deq_pkg::CMD_PUSH_FRONT ||
                                i_cmd.cmd == deq_pkg::CMD_PUSH_BACK))
        |=> ($stable(r_count) && $stable(r_head)))
        else $error("push into full queue changed state");

    a_load_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::ST_LOAD && !out_free)
        |=> (r_state == deq_pkg::ST_LOAD && r_out_valid))
        else $error("result lost under back-pressure");

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the ring-buffer double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SHOW_MAX    = 10;

    // Spare command codes; the block must treat them as no-ops.
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [deq_pkg::FIELD_W-1:0]   read_value;
        logic [deq_pkg::FIELD_W-1:0]   front_value;
        logic [deq_pkg::FIELD_W-1:0]   back_value;
        logic [deq_pkg::CNT_OUT_W-1:0] item_count;
        logic [deq_pkg::STAT_W-1:0]    status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    deq_cmd_if cmd_ch ();
    deq_res_if res_ch ();

    double_ended_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // Shadow deque: ring storage, head slot and element count.
    deq_pkg::t_data model_ring [deq_pkg::DEPTH];
    int    model_head;
    int    model_count;

    t_outcome pending_outcomes [$];

    int  cycle_count;
    int  fail_count;
    int  requests_sent;
    int  results_checked;
    int  full_seen, empty_seen, range_seen;
    bit  no_idle;

    // ---------------------------------------------------------------
    // Shadow deque update
    // ---------------------------------------------------------------
    function automatic int ring_slot(int off);
        int s;
        s = model_head + off;
        if (s >= deq_pkg::DEPTH) s -= deq_pkg::DEPTH;
        return s;
    endfunction

    function automatic t_outcome deque_apply(logic [deq_pkg::CMD_W-1:0] cmd,
                                             logic [deq_pkg::FIELD_W-1:0] value,
                                             logic [deq_pkg::POS_W-1:0] pos);
        t_outcome o;
        o = '0;
        o.status = deq_pkg::STAT_OK;
        case (cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
                if (model_count >= deq_pkg::DEPTH) begin
                    o.status = deq_pkg::STAT_FULL;
                end else begin
                    model_head = (model_head == 0) ? deq_pkg::DEPTH - 1 : model_head - 1;
                    model_ring[model_head] = deq_pkg::t_data'(value);
                    model_count++;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (model_count >= deq_pkg::DEPTH) begin
                    o.status = deq_pkg::STAT_FULL;
                end else begin
                    model_ring[ring_slot(model_count)] = deq_pkg::t_data'(value);
                    model_count++;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (model_count == 0) begin
                    o.status = deq_pkg::STAT_EMPTY;
                end else begin
                    model_head = ring_slot(1);
                    model_count--;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (model_count == 0) o.status = deq_pkg::STAT_EMPTY;
                else model_count--;
            end
            deq_pkg::CMD_READ: begin
                if (model_count == 0) begin
                    o.status = deq_pkg::STAT_EMPTY;
                end else if (int'(pos) >= model_count) begin
                    o.status = deq_pkg::STAT_RANGE;
                end else begin
                    o.read_value = deq_pkg::FIELD_W'(model_ring[ring_slot(int'(pos))]);
                end
            end
            deq_pkg::CMD_CLEAR: begin
                model_count = 0;
                model_head  = 0;
            end
            default: ;
        endcase
        if (model_count != 0) begin
            o.front_value = deq_pkg::FIELD_W'(model_ring[model_head]);
            o.back_value  = deq_pkg::FIELD_W'(model_ring[ring_slot(model_count - 1)]);
        end
        o.item_count = deq_pkg::CNT_OUT_W'(model_count);
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: entered and left at a falling edge.
    // valid is only lowered when a gap is drawn, so a back-to-back
    // request keeps it high with no glitch.
    // ---------------------------------------------------------------
    task automatic send_request(logic [deq_pkg::CMD_W-1:0] cmd,
                                logic [deq_pkg::FIELD_W-1:0] value,
                                logic [deq_pkg::POS_W-1:0] pos);
        int       gap;
        t_outcome next_outcome;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.cmd           = cmd;
        cmd_ch.push_value    = value;
        cmd_ch.read_position = pos;
        cmd_ch.valid         = 1'b1;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        next_outcome     = deque_apply(cmd, value, pos);
        pending_outcomes = {pending_outcomes, next_outcome};
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Hold the request channel idle until every result is back.
    task automatic wait_all_results();
        cmd_ch.valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [deq_pkg::FIELD_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Mostly an in-range position, sometimes anything the field holds.
    function automatic logic [deq_pkg::POS_W-1:0] pick_position();
        if (model_count > 0 && $urandom_range(0, 4) != 0)
            return deq_pkg::POS_W'($urandom_range(0, model_count - 1));
        return deq_pkg::POS_W'($urandom_range(0, 15));
    endfunction

    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            send_request(deq_pkg::CMD_PUSH_FRONT, random_value(), deq_pkg::POS_W'($urandom));
        else if (r < 50)
            send_request(deq_pkg::CMD_PUSH_BACK, random_value(), deq_pkg::POS_W'($urandom));
        else if (r < 62)
            send_request(deq_pkg::CMD_POP_FRONT, random_value(), deq_pkg::POS_W'($urandom));
        else if (r < 74)
            send_request(deq_pkg::CMD_POP_BACK, random_value(), deq_pkg::POS_W'($urandom));
        else if (r < 94)
            send_request(deq_pkg::CMD_READ, random_value(), pick_position());
        else if (r < 97)
            send_request(deq_pkg::CMD_CLEAR, random_value(), deq_pkg::POS_W'($urandom));
        else
            send_request(deq_pkg::CMD_W'($urandom_range(0, 7)), random_value(),
                         deq_pkg::POS_W'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Empty, full, out-of-range, spare codes and clear, with extreme values.
    task automatic test_directed();
        int i;
        send_request(deq_pkg::CMD_POP_FRONT, '0, '0);
        send_request(deq_pkg::CMD_POP_BACK, '1, '1);
        send_request(deq_pkg::CMD_READ, '0, 4'd15);
        for (i = 0; i < deq_pkg::DEPTH / 2; i++) begin
            send_request(deq_pkg::CMD_PUSH_FRONT,
                         (i % 2) ? 32'hFFFF_FFFF : 32'hA5A5_0000 + i, '0);
            send_request(deq_pkg::CMD_PUSH_BACK,
                         (i % 2) ? 32'h0000_0000 : 32'h5A5A_FFF0 + i, '1);
        end
        send_request(deq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, '0);
        send_request(deq_pkg::CMD_PUSH_BACK, 32'h8765_4321, '0);
        send_request(deq_pkg::CMD_READ, '0, 4'd15);
        send_request(deq_pkg::CMD_POP_FRONT, '0, '0);
        send_request(deq_pkg::CMD_POP_BACK, '0, '0);
        send_request(deq_pkg::CMD_READ, '1, 4'd14);
        send_request(CMD_SPARE_6, '1, 4'd3);
        send_request(CMD_SPARE_7, '1, 4'd0);
        send_request(deq_pkg::CMD_CLEAR, '1, '1);
    endtask

    task automatic test_random_mix(int n);
        repeat (n) send_random_request();
    endtask

    // Fill past full, then drain past empty, with reads mixed in.
    task automatic test_fill_drain(int rounds);
        int extra;
        repeat (rounds) begin
            extra = $urandom_range(1, 3);
            while (model_count < deq_pkg::DEPTH || extra > 0) begin
                if (model_count == deq_pkg::DEPTH) extra--;
                if ($urandom_range(0, 5) == 0)
                    send_request(deq_pkg::CMD_READ, random_value(), pick_position());
                else
                    send_request($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT
                                                      : deq_pkg::CMD_PUSH_BACK,
                                 random_value(), deq_pkg::POS_W'($urandom));
            end
            extra = $urandom_range(1, 2);
            while (model_count > 0 || extra > 0) begin
                if (model_count == 0) extra--;
                if ($urandom_range(0, 5) == 0)
                    send_request(deq_pkg::CMD_READ, random_value(), pick_position());
                else
                    send_request($urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT
                                                      : deq_pkg::CMD_POP_BACK,
                                 random_value(), deq_pkg::POS_W'($urandom));
            end
        end
    endtask

    // Both sides at full rate.
    task automatic test_no_idle(int n);
        no_idle = 1'b1;
        test_random_mix(n);
        no_idle = 1'b0;
    endtask

    // Short bursts, each followed by a pause until the results are all in.
    task automatic test_paused_bursts(int bursts);
        repeat (bursts) begin
            repeat ($urandom_range(1, 16)) send_random_request();
            wait_all_results();
            @(negedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall per result, then compare.
    // ---------------------------------------------------------------
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge i_clk);
        end
    end

    t_outcome want, got;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.read_value  = res_ch.read_value;
            got.front_value = res_ch.front_value;
            got.back_value  = res_ch.back_value;
            got.item_count  = res_ch.item_count;
            got.status      = res_ch.status;
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_MAX)
                    $display("[%0d] unexpected result: rd=%h fr=%h bk=%h cnt=%0d st=%0d",
                             cycle_count, got.read_value, got.front_value,
                             got.back_value, got.item_count, got.status);
            end else begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                results_checked++;
                case (want.status)
                    deq_pkg::STAT_FULL:  full_seen++;
                    deq_pkg::STAT_EMPTY: empty_seen++;
                    deq_pkg::STAT_RANGE: range_seen++;
                    default: ;
                endcase
                if (got.read_value !== want.read_value || got.front_value !== want.front_value
                        || got.back_value !== want.back_value
                        || got.item_count !== want.item_count
                        || got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX) begin
                        $display("[%0d] result %0d mismatch", cycle_count, results_checked);
                        $display("  expected rd=%h fr=%h bk=%h cnt=%0d st=%0d",
                                 want.read_value, want.front_value, want.back_value,
                                 want.item_count, want.status);
                        $display("  actual   rd=%h fr=%h bk=%h cnt=%0d st=%0d",
                                 got.read_value, got.front_value, got.back_value,
                                 got.item_count, got.status);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.cmd           = '0;
        cmd_ch.push_value    = '0;
        cmd_ch.read_position = '0;
        model_head           = 0;
        model_count          = 0;
        for (int k = 0; k < deq_pkg::DEPTH; k++) model_ring[k] = '0;
        cycle_count     = 0;
        fail_count      = 0;
        requests_sent   = 0;
        results_checked = 0;
        full_seen       = 0;
        empty_seen      = 0;
        range_seen      = 0;
        no_idle         = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_mix(550);
        test_fill_drain(6);
        test_no_idle(200);
        test_paused_bursts(28);

        // Drain, then give the pipeline time to show any stray result.
        wait_all_results();
        repeat (12) @(negedge i_clk);

        $display("Ran %0d requests, checked %0d results in %0d cycles.",
                 requests_sent, results_checked, cycle_count);
        $display("Saw %0d full pushes, %0d empty pops/reads, %0d out-of-range reads; %0d errors.",
                 full_seen, empty_seen, range_seen, fail_count);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* double_ended_queue_top.f */
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_mem.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_top.sv
dv/testbench.sv
